// ===== hw/rtl/pfc_pkg.sv =====
`default_nettype none

package pfc_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 11;
	localparam int DIV_W = 16;
	localparam int SQ_W = 32;
	localparam int STEP_W = 4;
	localparam int COUNT_FIELD_MAX = 2047;

	localparam logic [DIV_W-1:0] DIV_FIRST = 16'd3;
	localparam logic [SQ_W-1:0] SQ_FIRST = 32'd9;
	localparam logic [VALUE_W-1:0] VALUE_TWO = 32'd2;

	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic last;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value_out;
		logic is_prime;
		logic [COUNT_W-1:0] prime_count;
		logic last_out;
	} out_word_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_START,
		OP_STEP,
		OP_SET_P,
		OP_CLR_P,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_IN,
		C_LE1,
		C_EQ2,
		C_EVEN,
		C_SQ_GT,
		C_REM_BUSY,
		C_REM_ZERO,
		C_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t op;
		cond_t cond;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic in_valid;
		logic le1;
		logic eq2;
		logic even;
		logic sq_gt;
		logic rem_busy;
		logic rem_zero;
		logic out_busy;
	} status_t;

	localparam step_t S_FETCH = 4'd0;
	localparam step_t S_LE1 = 4'd1;
	localparam step_t S_EQ2 = 4'd2;
	localparam step_t S_EVEN = 4'd3;
	localparam step_t S_LOOP = 4'd4;
	localparam step_t S_DIV = 4'd5;
	localparam step_t S_WAIT = 4'd6;
	localparam step_t S_TEST = 4'd7;
	localparam step_t S_BACK = 4'd8;
	localparam step_t S_PRIME = 4'd9;
	localparam step_t S_NOTP = 4'd10;
	localparam step_t S_EMIT = 4'd11;
	localparam step_t S_RET = 4'd12;

	// control store: a jump is taken when its condition holds, else step + 1
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		w = '{op: OP_NOP, cond: C_ALWAYS, target: S_FETCH};
		unique case (step)
			S_FETCH: w = '{op: OP_LOAD, cond: C_NO_IN, target: S_FETCH};
			S_LE1: w = '{op: OP_NOP, cond: C_LE1, target: S_NOTP};
			S_EQ2: w = '{op: OP_NOP, cond: C_EQ2, target: S_PRIME};
			S_EVEN: w = '{op: OP_NOP, cond: C_EVEN, target: S_NOTP};
			S_LOOP: w = '{op: OP_NOP, cond: C_SQ_GT, target: S_PRIME};
			S_DIV: w = '{op: OP_START, cond: C_NEVER, target: S_FETCH};
			S_WAIT: w = '{op: OP_NOP, cond: C_REM_BUSY, target: S_WAIT};
			S_TEST: w = '{op: OP_STEP, cond: C_REM_ZERO, target: S_NOTP};
			S_BACK: w = '{op: OP_NOP, cond: C_ALWAYS, target: S_LOOP};
			S_PRIME: w = '{op: OP_SET_P, cond: C_ALWAYS, target: S_EMIT};
			S_NOTP: w = '{op: OP_CLR_P, cond: C_NEVER, target: S_FETCH};
			S_EMIT: w = '{op: OP_EMIT, cond: C_OUT_BUSY, target: S_EMIT};
			S_RET: w = '{op: OP_NOP, cond: C_ALWAYS, target: S_FETCH};
			default: w = '{op: OP_NOP, cond: C_ALWAYS, target: S_FETCH};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/prime_filter_counter_top.sv =====
`default_nettype none

// Trial-division primality filter. Each word on in_data gives one word on out_data
// carrying the value, its prime flag, the running prime count of the current array
// (saturating at MAX_ITEMS, or 2047 if MAX_ITEMS is larger) and the last flag; the
// count clears after the word marked last. One word is worked on at a time by a
// microcoded sequencer. A value of 1 or less, 2, or an even value is decided
// without the divisor loop; an odd value is tried against the odd divisors from 3
// upward while the divisor's square is no more than the value, and is prime if none
// divides it. Each divisor passes through the serial remainder unit and the loop
// control. After a result is registered the sequencer returns through S_RET to
// S_FETCH, where the next word is accepted. The result register lets the next word
// be accepted while a result waits on out_ready.
module prime_filter_counter_top #(
	parameter int MAX_ITEMS = 1024
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire pfc_pkg::in_word_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output pfc_pkg::out_word_t out_data
);

	localparam logic [pfc_pkg::COUNT_W-1:0] COUNT_LIMIT = pfc_pkg::COUNT_W'(
		(MAX_ITEMS < pfc_pkg::COUNT_FIELD_MAX) ? MAX_ITEMS : pfc_pkg::COUNT_FIELD_MAX);

	pfc_pkg::op_t op;
	pfc_pkg::status_t status;
	logic fetch;
	logic signed [pfc_pkg::VALUE_W-1:0] value;
	logic last;
	logic prime;
	logic le1;
	logic eq2;
	logic even;
	logic sq_gt;
	logic rem_busy;
	logic rem_zero;
	logic out_free;
	logic emit;
	logic out_valid_q;
	pfc_pkg::out_word_t out_q;
	logic [pfc_pkg::COUNT_W-1:0] count_q;
	logic [pfc_pkg::COUNT_W-1:0] count_next;

	assign out_free = !out_valid_q || out_ready;
	assign emit = (op == pfc_pkg::OP_EMIT) && out_free;

	assign status = '{
		in_valid: in_valid,
		le1: le1,
		eq2: eq2,
		even: even,
		sq_gt: sq_gt,
		rem_busy: rem_busy,
		rem_zero: rem_zero,
		out_busy: !out_free
	};

	pfc_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.status(status),
		.op(op),
		.fetch(fetch)
	);

	pfc_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.in_data(in_data),
		.value(value),
		.last(last),
		.prime(prime),
		.le1(le1),
		.eq2(eq2),
		.even(even),
		.sq_gt(sq_gt),
		.rem_busy(rem_busy),
		.rem_zero(rem_zero)
	);

	assign count_next = (prime && (count_q < COUNT_LIMIT)) ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				count_q <= last ? '0 : count_next;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.value_out <= value;
			out_q.is_prime <= prime;
			out_q.prime_count <= count_next;
			out_q.last_out <= last;
		end
	end

	assign in_ready = fetch;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pfc_rem.sv =====
`default_nettype none

// serial restoring remainder, one dividend bit per cycle
module pfc_rem (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [pfc_pkg::VALUE_W-1:0] dividend,
	input wire logic [pfc_pkg::DIV_W-1:0] divisor,
	output logic busy,
	output logic zero
);

	localparam int CNT_W = $clog2(pfc_pkg::VALUE_W);

	logic busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [pfc_pkg::VALUE_W-1:0] dvd_q;
	logic [pfc_pkg::DIV_W-1:0] rem_q;
	logic [pfc_pkg::DIV_W:0] shifted;
	logic [pfc_pkg::DIV_W:0] diff;

	assign shifted = {rem_q, dvd_q[pfc_pkg::VALUE_W-1]};
	assign diff = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(pfc_pkg::VALUE_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[pfc_pkg::VALUE_W-2:0], 1'b0};
			// remainder stays below the divisor, so the low bits suffice
			if (shifted >= {1'b0, divisor}) begin
				rem_q <= diff[pfc_pkg::DIV_W-1:0];
			end else begin
				rem_q <= shifted[pfc_pkg::DIV_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign zero = (rem_q == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/pfc_dpath.sv =====
`default_nettype none

module pfc_dpath (
	input wire logic clk,
	input wire logic arst_n,
	input wire pfc_pkg::op_t op,
	input wire pfc_pkg::in_word_t in_data,
	output logic signed [pfc_pkg::VALUE_W-1:0] value,
	output logic last,
	output logic prime,
	output logic le1,
	output logic eq2,
	output logic even,
	output logic sq_gt,
	output logic rem_busy,
	output logic rem_zero
);

	logic signed [pfc_pkg::VALUE_W-1:0] value_q;
	logic last_q;
	logic prime_q;
	logic [pfc_pkg::DIV_W-1:0] d_q;
	logic [pfc_pkg::SQ_W-1:0] sq_q;
	logic [pfc_pkg::DIV_W+1:0] sq_inc;

	// (d + 2)^2 = d^2 + 4d + 4
	assign sq_inc = {d_q, 2'b00} + (pfc_pkg::DIV_W+2)'(4);

	always_ff @(posedge clk) begin
		unique case (op)
			pfc_pkg::OP_LOAD: begin
				value_q <= in_data.value;
				last_q <= in_data.last;
				d_q <= pfc_pkg::DIV_FIRST;
				sq_q <= pfc_pkg::SQ_FIRST;
			end
			pfc_pkg::OP_STEP: begin
				d_q <= d_q + pfc_pkg::DIV_W'(2);
				sq_q <= sq_q + pfc_pkg::SQ_W'(sq_inc);
			end
			pfc_pkg::OP_SET_P: prime_q <= 1'b1;
			pfc_pkg::OP_CLR_P: prime_q <= 1'b0;
			pfc_pkg::OP_NOP, pfc_pkg::OP_START, pfc_pkg::OP_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	pfc_rem u_rem (
		.clk(clk),
		.arst_n(arst_n),
		.start(op == pfc_pkg::OP_START),
		.dividend(value_q),
		.divisor(d_q),
		.busy(rem_busy),
		.zero(rem_zero)
	);

	// negative values count as not prime
	assign le1 = value_q[pfc_pkg::VALUE_W-1] || (value_q[pfc_pkg::VALUE_W-2:1] == '0);
	assign eq2 = (value_q == pfc_pkg::VALUE_TWO);
	assign even = !value_q[0];
	assign sq_gt = (sq_q > value_q);

	assign value = value_q;
	assign last = last_q;
	assign prime = prime_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pfc_seq.sv =====
`default_nettype none

module pfc_seq (
	input wire logic clk,
	input wire logic arst_n,
	input wire pfc_pkg::status_t status,
	output pfc_pkg::op_t op,
	output logic fetch
);

	pfc_pkg::step_t pc_q;
	pfc_pkg::ucode_t uw;
	logic take;

	assign uw = pfc_pkg::ucode_rom(pc_q);

	always_comb begin
		unique case (uw.cond)
			pfc_pkg::C_NEVER: take = 1'b0;
			pfc_pkg::C_ALWAYS: take = 1'b1;
			pfc_pkg::C_NO_IN: take = !status.in_valid;
			pfc_pkg::C_LE1: take = status.le1;
			pfc_pkg::C_EQ2: take = status.eq2;
			pfc_pkg::C_EVEN: take = status.even;
			pfc_pkg::C_SQ_GT: take = status.sq_gt;
			pfc_pkg::C_REM_BUSY: take = status.rem_busy;
			pfc_pkg::C_REM_ZERO: take = status.rem_zero;
			pfc_pkg::C_OUT_BUSY: take = status.out_busy;
			default: take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= pfc_pkg::S_FETCH;
		end else if (take) begin
			pc_q <= uw.target;
		end else begin
			pc_q <= pc_q + 1'b1;
		end
	end

	assign op = uw.op;
	assign fetch = (pc_q == pfc_pkg::S_FETCH);

endmodule

`default_nettype wire
